// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the escaper rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/qse_pkg.sv
// ----------------------------------------------------------------------------
// qse_pkg
// types, character constants and the byte classifier of the string escaper
// ----------------------------------------------------------------------------
package qse_pkg;

  localparam logic [7:0] QUOTE_CH     = 8'h27;
  localparam logic [7:0] BACKSLASH_CH = 8'h5C;
  localparam logic [7:0] PRINT_LO     = 8'd32;
  localparam logic [7:0] PRINT_HI     = 8'd126;
  localparam logic [7:0] HIGH_LO      = 8'd160;
  localparam logic [7:0] DIGIT_ZERO   = 8'h30;
  localparam logic [7:0] NO_LETTER    = 8'h00;

  // how the back end expands one word
  typedef enum logic [1:0] {
    CLS_PASS,   // byte as is
    CLS_ESC,    // backslash then ch
    CLS_OCT,    // backslash then three octal digits of ch
    CLS_EMPTY   // two quotes only
  } cls_t;

  typedef struct packed {
    cls_t       cls;
    logic [7:0] ch;
    logic       starts;
    logic       ends;
  } desc_t;

  function automatic logic [7:0] control_letter(input logic [7:0] c);
    logic [7:0] r;
    r = NO_LETTER;
    unique case (c)
      8'd7:    r = 8'h61; // a
      8'd8:    r = 8'h62; // b
      8'd9:    r = 8'h74; // t
      8'd10:   r = 8'h6E; // n
      8'd11:   r = 8'h76; // v
      8'd12:   r = 8'h66; // f
      8'd13:   r = 8'h72; // r
      default: r = NO_LETTER;
    endcase
    return r;
  endfunction

  function automatic desc_t classify(input logic [7:0] c, input logic starts,
                                     input logic ends, input logic empty);
    desc_t      d;
    logic [7:0] letter;
    letter   = control_letter(c);
    d.ch     = c;
    d.starts = starts;
    d.ends   = ends;
    if (empty) begin
      d.cls    = CLS_EMPTY;
      d.starts = 1'b0;
      d.ends   = 1'b0;
    end else if (c == QUOTE_CH || c == BACKSLASH_CH) begin
      d.cls = CLS_ESC;
    end else if ((c >= PRINT_LO && c <= PRINT_HI) || c >= HIGH_LO) begin
      d.cls = CLS_PASS;
    end else if (letter != NO_LETTER) begin
      d.cls = CLS_ESC;
      d.ch  = letter;
    end else begin
      d.cls = CLS_OCT;
    end
    return d;
  endfunction

endpackage

// File: rtl/qse_front.sv
// ----------------------------------------------------------------------------
// qse_front
// input stage: takes raw characters, classifies them, pushes descriptors
// ----------------------------------------------------------------------------
module qse_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    char_byte,
  input  logic          starts_string,
  input  logic          ends_string,
  input  logic          empty_string,
  output logic          push,
  output qse_pkg::desc_t push_desc,
  input  logic          queue_full
);
  import qse_pkg::*;

  logic  held;
  desc_t desc;

  assign push      = held && !queue_full;
  assign push_desc = desc;
  assign in_ready  = !held || !queue_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      desc <= classify(char_byte, starts_string, ends_string, empty_string);
    end
  end

endmodule

// File: rtl/qse_queue.sv
// ----------------------------------------------------------------------------
// qse_queue
// small descriptor queue between the front and back ends
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qse_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  qse_pkg::desc_t push_desc,
  output logic           full,
  input  logic           pop,
  output qse_pkg::desc_t head_desc,
  output logic           not_empty
);
  import qse_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  desc_t         slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign head_desc = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_CLK(a_no_overflow, clk, rst, !(push && full), "push into a full queue")
  `ASSERT_CLK(a_no_underflow, clk, rst, !(pop && !not_empty), "pop from an empty queue")
  `ASSERT_ALWAYS(a_count_range, clk, rst || count <= CW'(DEPTH), "queue count out of range")

endmodule

// File: rtl/qse_back.sv
// ----------------------------------------------------------------------------
// qse_back
// output sequencer: expands one descriptor into its escaped bytes
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qse_back (
  input  logic           clk,
  input  logic           rst,
  input  qse_pkg::desc_t head_desc,
  input  logic           not_empty,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           last_of_run
);
  import qse_pkg::*;

  logic [2:0] pos;
  logic [2:0] body_len;
  logic [2:0] total;
  logic [2:0] body_idx;
  logic [7:0] body_byte;
  logic [7:0] cur_byte;
  logic       cur_last;
  logic       produce;

  always_comb begin
    unique case (head_desc.cls)
      CLS_PASS:  body_len = 3'd1;
      CLS_ESC:   body_len = 3'd2;
      CLS_OCT:   body_len = 3'd4;
      CLS_EMPTY: body_len = 3'd2;
      default:   body_len = 3'd1;
    endcase
  end

  assign total    = {2'b00, head_desc.starts} + body_len + {2'b00, head_desc.ends};
  assign body_idx = pos - {2'b00, head_desc.starts};

  always_comb begin
    body_byte = BACKSLASH_CH;
    unique case (head_desc.cls)
      CLS_PASS:  body_byte = head_desc.ch;
      CLS_ESC:   body_byte = (body_idx == 3'd0) ? BACKSLASH_CH : head_desc.ch;
      CLS_EMPTY: body_byte = QUOTE_CH;
      CLS_OCT: begin
        case (body_idx)
          3'd0:    body_byte = BACKSLASH_CH;
          3'd1:    body_byte = DIGIT_ZERO + {6'd0, head_desc.ch[7:6]};
          3'd2:    body_byte = DIGIT_ZERO + {5'd0, head_desc.ch[5:3]};
          default: body_byte = DIGIT_ZERO + {5'd0, head_desc.ch[2:0]};
        endcase
      end
      default:   body_byte = head_desc.ch;
    endcase
  end

  // opening quote, then body, then closing quote
  always_comb begin
    if (head_desc.starts && pos == 3'd0) begin
      cur_byte = QUOTE_CH;
    end else if (body_idx < body_len) begin
      cur_byte = body_byte;
    end else begin
      cur_byte = QUOTE_CH;
    end
  end

  assign cur_last = (pos == total - 3'd1);
  assign produce  = not_empty && (!out_valid || out_ready);
  assign pop      = produce && cur_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (produce) begin
        pos       <= cur_last ? 3'd0 : pos + 3'd1;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      out_byte    <= cur_byte;
      last_of_run <= cur_last;
    end
  end

  `ASSERT_CLK(a_mid_item_held, clk, rst, pos != 3'd0 |-> not_empty, "expansion lost its word")
  `ASSERT_CLK(a_pos_range, clk, rst, pos < 3'd6, "output position beyond six bytes")

endmodule

// File: rtl/quoted_string_escaper.sv
// ----------------------------------------------------------------------------
// quoted_string_escaper
// c-style quoting and escaping of a byte string, one character word in
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | in_valid / in_ready  | char_byte, starts_string, ends_string, empty_string
//  out     | out_valid / out_ready| out_byte, last_of_run
//
// each input word yields 1 to 6 output words, one per cycle from the back end
// while out_ready is high; octal escapes with both quotes give 6, plain characters 1
// the output byte stream sets the rate; DEPTH words buffer between the ends
// first output word passes the input register, a queue slot and the output register
// synchronous reset empties the input register, queue and output register
// ----------------------------------------------------------------------------
module quoted_string_escaper #(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_byte,
  input  logic       starts_string,
  input  logic       ends_string,
  input  logic       empty_string,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last_of_run
);
  import qse_pkg::*;

  logic  push;
  logic  pop;
  logic  full;
  logic  not_empty;
  desc_t push_desc;
  desc_t head_desc;

  qse_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .char_byte     (char_byte),
    .starts_string (starts_string),
    .ends_string   (ends_string),
    .empty_string  (empty_string),
    .push          (push),
    .push_desc     (push_desc),
    .queue_full    (full)
  );

  qse_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .full      (full),
    .pop       (pop),
    .head_desc (head_desc),
    .not_empty (not_empty)
  );

  qse_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_desc   (head_desc),
    .not_empty   (not_empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

endmodule

// File: sim/tb_quoted_string_escaper.sv
// ----------------------------------------------------------------------------
// tb_quoted_string_escaper
// self-checking testbench for the quoted string escaper
// ----------------------------------------------------------------------------
// character words go in on a valid/ready channel, with random idle bursts on
// the sending side and random stalls on the receiving side. each accepted
// word is expanded by a local predictor into its escaped, quoted text. each
// output word is checked against the oldest predicted byte, on both the byte
// and the end-of-run flag. the run covers directed corner characters, well
// formed random strings, random noise words, a pause until the output has
// drained, and a final back-to-back stretch with no idling at all.
// ----------------------------------------------------------------------------
module tb_quoted_string_escaper;
  timeunit 1ns;
  timeprecision 1ps;

  import qse_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;

  localparam logic [7:0] CTL_BEL = 8'h07;
  localparam logic [7:0] CTL_BS  = 8'h08;
  localparam logic [7:0] CTL_TAB = 8'h09;
  localparam logic [7:0] CTL_LF  = 8'h0A;
  localparam logic [7:0] CTL_VT  = 8'h0B;
  localparam logic [7:0] CTL_FF  = 8'h0C;
  localparam logic [7:0] CTL_CR  = 8'h0D;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } esc_word_t;

  logic       clk           = 1'b0;
  logic       rst           = 1'b1;
  logic       in_valid      = 1'b0;
  logic       in_ready;
  logic [7:0] char_byte     = 8'h00;
  logic       starts_string = 1'b0;
  logic       ends_string   = 1'b0;
  logic       empty_string  = 1'b0;
  logic       out_valid;
  logic       out_ready     = 1'b0;
  logic [7:0] out_byte;
  logic       last_of_run;

  esc_word_t  expected_text [$];
  esc_word_t  head;
  bit         calm = 1'b0;
  int         n_errors = 0;
  int         n_items  = 0;
  int         n_bytes  = 0;
  int         n_empty  = 0;
  int         n_octal  = 0;
  int         n_named  = 0;
  int         n_quoted = 0;
  int         n_plain  = 0;
  int         quiet_cycles = 0;

  quoted_string_escaper dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .char_byte    (char_byte),
    .starts_string(starts_string),
    .ends_string  (ends_string),
    .empty_string (empty_string),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .last_of_run  (last_of_run)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    n_errors++;
  endtask

  function automatic logic [7:0] escape_letter(input logic [7:0] c);
    case (c)
      CTL_BEL: return "a";
      CTL_BS:  return "b";
      CTL_TAB: return "t";
      CTL_LF:  return "n";
      CTL_VT:  return "v";
      CTL_FF:  return "f";
      CTL_CR:  return "r";
      default: return NO_LETTER;
    endcase
  endfunction

  // expands one accepted word into the escaped text it must produce
  function automatic void escape_char(input logic [7:0] c, input logic s,
                                      input logic e, input logic z);
    logic [7:0] seq [$];
    logic [7:0] letter;
    letter = escape_letter(c);
    if (z) begin
      seq.push_back(QUOTE_CH);
      seq.push_back(QUOTE_CH);
      n_empty++;
    end else begin
      if (s) seq.push_back(QUOTE_CH);
      if (c == QUOTE_CH || c == BACKSLASH_CH) begin
        seq.push_back(BACKSLASH_CH);
        seq.push_back(c);
        n_quoted++;
      end else if ((c >= PRINT_LO && c <= PRINT_HI) || c >= HIGH_LO) begin
        seq.push_back(c);
        n_plain++;
      end else if (letter != NO_LETTER) begin
        seq.push_back(BACKSLASH_CH);
        seq.push_back(letter);
        n_named++;
      end else begin
        seq.push_back(BACKSLASH_CH);
        seq.push_back(DIGIT_ZERO + {6'd0, c[7:6]});
        seq.push_back(DIGIT_ZERO + {5'd0, c[5:3]});
        seq.push_back(DIGIT_ZERO + {5'd0, c[2:0]});
        n_octal++;
      end
      if (e) seq.push_back(QUOTE_CH);
    end
    foreach (seq[i]) expected_text.push_back('{b: seq[i], last: (i == seq.size() - 1)});
  endfunction

  // biased toward the escape classes, with some fully random bytes
  function automatic logic [7:0] pick_char();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0, 1, 2: c = 8'($urandom_range(32, 126));
      3:       c = 8'($urandom_range(160, 255));
      4:       c = $urandom_range(0, 1) ? QUOTE_CH : BACKSLASH_CH;
      5:       c = 8'($urandom_range(7, 13));
      6:       c = 8'($urandom_range(0, 31));
      7:       c = 8'($urandom_range(127, 159));
      default: c = 8'($urandom);
    endcase
    return c;
  endfunction

  // sends one word, then maybe idles the input for a burst
  task automatic send_char(input logic [7:0] c, input logic s, input logic e,
                           input logic z);
    char_byte     <= c;
    starts_string <= s;
    ends_string   <= e;
    empty_string  <= z;
    in_valid      <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    escape_char(c, s, e, z);
    n_items++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // one string of random content with matching quote flags
  task automatic send_string(input int len);
    for (int i = 0; i < len; i++) send_char(pick_char(), i == 0, i == len - 1, 1'b0);
  endtask

  task automatic test_directed();
    send_char(8'h00, 1'b0, 1'b0, 1'b1);            // empty string
    send_char(8'hFF, 1'b1, 1'b1, 1'b1);            // empty string, other fields ignored
    send_char(8'h00, 1'b1, 1'b1, 1'b0);            // zero byte, six words out
    send_char(8'h00, 1'b0, 1'b0, 1'b0);            // zero byte in the middle
    send_char(8'hFF, 1'b1, 1'b1, 1'b0);
    send_char(8'h1F, 1'b1, 1'b0, 1'b0);            // opening quote only
    send_char(PRINT_LO, 1'b0, 1'b0, 1'b0);
    send_char(PRINT_HI, 1'b0, 1'b0, 1'b0);
    send_char(8'h7F, 1'b0, 1'b0, 1'b0);
    send_char(8'h80, 1'b0, 1'b0, 1'b0);
    send_char(8'h9F, 1'b0, 1'b0, 1'b0);
    send_char(HIGH_LO, 1'b0, 1'b1, 1'b0);          // closing quote only
    send_char(QUOTE_CH, 1'b1, 1'b1, 1'b0);
    send_char(BACKSLASH_CH, 1'b1, 1'b1, 1'b0);
    send_char(CTL_BEL, 1'b1, 1'b0, 1'b0);
    send_char(CTL_BS, 1'b0, 1'b0, 1'b0);
    send_char(CTL_TAB, 1'b0, 1'b0, 1'b0);
    send_char(CTL_LF, 1'b0, 1'b0, 1'b0);
    send_char(CTL_VT, 1'b0, 1'b0, 1'b0);
    send_char(CTL_FF, 1'b0, 1'b0, 1'b0);
    send_char(CTL_CR, 1'b0, 1'b1, 1'b0);
    send_char(8'h06, 1'b0, 1'b0, 1'b0);            // just below the named controls
    send_char(8'h0E, 1'b0, 1'b0, 1'b0);            // just above them
  endtask

  task automatic test_random_strings(input int count);
    int stop_at;
    stop_at = n_items + count;
    while (n_items < stop_at) begin
      if ($urandom_range(0, 9) == 0) send_char(8'($urandom), 1'($urandom), 1'($urandom), 1'b1);
      else send_string($urandom_range(1, 10));
    end
  endtask

  // unmatched flags and arbitrary field values
  task automatic test_noise(input int count);
    repeat (count) send_char(8'($urandom), 1'($urandom), 1'($urandom),
                             $urandom_range(0, 5) == 0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk);
  endtask

  task automatic test_drain_pause();
    repeat (3) begin
      send_string($urandom_range(2, 6));
      wait_drained();
    end
  endtask

  task automatic test_back_to_back(input int count);
    calm = 1'b1;
    test_random_strings(count);
  endtask

  // output side stalls in bursts, with longer ready stretches between
  initial begin
    int span;
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        span = $urandom_range(1, 8);
      end else begin
        out_ready <= 1'b1;
        span = $urandom_range(1, 16);
      end
      repeat (span) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_text.size() == 0) begin
        report_error($sformatf("output word %h with nothing expected", out_byte));
      end else begin
        head = expected_text.pop_front();
        if (out_byte !== head.b)
          report_error($sformatf("out_byte %h, expected %h", out_byte, head.b));
        if (last_of_run !== head.last)
          report_error($sformatf("last_of_run %b, expected %b on byte %h",
                                 last_of_run, head.last, head.b));
        n_bytes++;
      end
    end
  end

  // ends the run when neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_strings(190);
    test_noise(60);
    test_drain_pause();
    test_back_to_back(80);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d words: %0d empty, %0d octal, %0d named control,",
             n_items, n_empty, n_octal, n_named);
    $display("  %0d quote or backslash, %0d plain; checked %0d output words",
             n_quoted, n_plain, n_bytes);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/qse_pkg.sv
rtl/qse_front.sv
rtl/qse_queue.sv
rtl/qse_back.sv
rtl/quoted_string_escaper.sv
sim/tb_quoted_string_escaper.sv
